FILE: rtl/core/ccw_pkg.sv
// Shared constants for the configuration capability walker.
package ccw_pkg;

    localparam int CFG_DWORDS   = 64;
    localparam int CFG_ADDR_W   = 6;
    localparam int MAX_HOPS_DEF = 48;

    localparam logic [CFG_ADDR_W-1:0] STATUS_DWORD   = 6'd1;
    localparam int                    STATUS_CAP_BIT = 20;
    localparam logic [CFG_ADDR_W-1:0] CAP_HEAD_DWORD = 6'd13;
    localparam logic [1:0]            CAP_HEAD_LANE  = 2'd0;
    localparam logic [7:0]            CAP_MIN_PTR    = 8'h40;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FIND  = 1'b1;

endpackage

FILE: rtl/core/config_capability_walker_core.sv
// Capability list walker over a 64-dword configuration space held in one memory.
// A write transaction returns no result; one transaction is handled at a time.
// A find transaction walks the list hop by hop over a single-port read memory: its result is
// registered from ST_RESULT, entered straight from acceptance when the list is absent and via
// ST_HEAD and at most MAX_HOPS ST_HOP steps otherwise, later while an earlier result waits.
// Reset clears the controller and the per-dword valid bits, so unwritten dwords read as zero.
module config_capability_walker_core #(
    parameter int MAX_HOPS = ccw_pkg::MAX_HOPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [5:0]  s_dword_index,
    input  logic [31:0] s_write_data,
    input  logic [7:0]  s_cap_id,
    input  logic [7:0]  s_prev_offset,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [7:0]  m_cap_offset
);

    localparam int HopW = $clog2(MAX_HOPS + 1);
    localparam logic [HopW-1:0] HopLimit = HopW'(MAX_HOPS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD,
        ST_HOP,
        ST_RESULT
    } state_t;

    state_t state_reg;

    logic [31:0] cfg_mem [ccw_pkg::CFG_DWORDS];
    logic [ccw_pkg::CFG_DWORDS-1:0] valid_reg;
    logic [31:0] rd_data_reg;
    logic        rd_valid_reg;
    logic        caps_reg;

    logic [7:0]      id_reg;
    logic [1:0]      lane_reg;
    logic [7:0]      ptr_reg;
    logic [HopW-1:0] hops_reg;
    logic            res_found_reg;
    logic [7:0]      res_offset_reg;
    logic            m_valid_reg;
    logic            m_found_reg;
    logic [7:0]      m_cap_offset_reg;

    logic                          accept;
    logic                          wr_en;
    logic                          rd_en;
    logic [ccw_pkg::CFG_ADDR_W-1:0] rd_addr;
    logic [31:0]                   rd_word;
    logic [7:0]                    head_byte;
    logic [7:0]                    prev_next;
    logic                          hop_match;
    logic [HopW-1:0]               hops_inc;
    logic                          head_go;
    logic                          hop_go;
    logic                          out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign wr_en    = accept && (s_opcode == ccw_pkg::OP_WRITE);
    assign out_free = !m_valid_reg || m_ready;

    // An unwritten dword reads as its reset value of zero.
    assign rd_word   = rd_valid_reg ? rd_data_reg : 32'd0;
    assign prev_next = s_prev_offset + 8'd1;

    always_comb begin
        case (lane_reg)
            2'd0:    head_byte = rd_word[7:0];
            2'd1:    head_byte = rd_word[15:8];
            2'd2:    head_byte = rd_word[23:16];
            default: head_byte = rd_word[31:24];
        endcase
    end

    assign hop_match = (rd_word[7:0] == id_reg);
    assign hops_inc  = hops_reg + HopW'(1);
    // The first hop is always within the limit, since the limit is at least one.
    assign head_go   = (head_byte >= ccw_pkg::CAP_MIN_PTR);
    assign hop_go    = (rd_word[15:8] >= ccw_pkg::CAP_MIN_PTR) && (hops_inc < HopLimit);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = ccw_pkg::CAP_HEAD_DWORD;
        unique case (state_reg)
            ST_IDLE: begin
                rd_en   = accept && (s_opcode == ccw_pkg::OP_FIND);
                rd_addr = (s_prev_offset == 8'd0) ? ccw_pkg::CAP_HEAD_DWORD : prev_next[7:2];
            end
            ST_HEAD: begin
                rd_en   = head_go;
                rd_addr = head_byte[7:2];
            end
            ST_HOP: begin
                rd_en   = !hop_match && hop_go;
                rd_addr = rd_word[15:10];
            end
            default: begin
                rd_en   = 1'b0;
                rd_addr = ccw_pkg::CAP_HEAD_DWORD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cfg_mem[s_dword_index] <= s_write_data;
        end
        if (rd_en) begin
            rd_data_reg <= cfg_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            caps_reg     <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[s_dword_index] <= 1'b1;
                if (s_dword_index == ccw_pkg::STATUS_DWORD) begin
                    caps_reg <= s_write_data[ccw_pkg::STATUS_CAP_BIT];
                end
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_RESULT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && (s_opcode == ccw_pkg::OP_FIND)) begin
                        id_reg         <= s_cap_id;
                        lane_reg       <= (s_prev_offset == 8'd0) ? ccw_pkg::CAP_HEAD_LANE
                                                                 : prev_next[1:0];
                        hops_reg       <= '0;
                        res_found_reg  <= 1'b0;
                        res_offset_reg <= 8'd0;
                        state_reg      <= caps_reg ? ST_HEAD : ST_RESULT;
                    end
                end
                ST_HEAD: begin
                    ptr_reg   <= {head_byte[7:2], 2'b00};
                    state_reg <= head_go ? ST_HOP : ST_RESULT;
                end
                ST_HOP: begin
                    if (hop_match) begin
                        res_found_reg  <= 1'b1;
                        res_offset_reg <= ptr_reg;
                        state_reg      <= ST_RESULT;
                    end else if (hop_go) begin
                        ptr_reg  <= {rd_word[15:10], 2'b00};
                        hops_reg <= hops_inc;
                    end else begin
                        state_reg <= ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    if (out_free) begin
                        m_valid_reg      <= 1'b1;
                        m_found_reg      <= res_found_reg;
                        m_cap_offset_reg <= res_offset_reg;
                        state_reg        <= ST_IDLE;
                    end else begin
                        m_valid_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_found      = m_found_reg;
    assign m_cap_offset = m_cap_offset_reg;

`ifndef SYNTHESIS
    // A match always lies in the capability area on a dword boundary.
    a_found_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_found) |-> (m_cap_offset[1:0] == 2'b00 && m_cap_offset >= 8'h40))
        else $error("found result with an offset outside the capability area");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_cap_offset == 8'd0))
        else $error("not-found result with a non-zero offset");

    // An accepted find keeps the input side closed until its result is registered.
    a_find_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_opcode == ccw_pkg::OP_FIND) |=> !s_ready)
        else $error("input accepted while a find is in progress");

    a_hop_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOP) |-> (hops_reg < HopLimit))
        else $error("hop counter ran past the hop limit");

    // A walk step never starts a memory read outside a find.
    a_read_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESULT) |-> !rd_en)
        else $error("memory read issued while holding a result");
`endif

endmodule
